@@ sv/pbam_pkg.sv @@
package pbam_pkg;

  localparam int ADDR_W        = 16;
  localparam int DATA_W        = 8;
  localparam int ROM_OFF_W     = 20;
  localparam int RAM_ADDR_W    = 16;
  localparam int PAGE_W        = 6;
  localparam int LOW_W         = 14;
  localparam int UNITS_W       = 7;
  localparam int ROM_UNITS_MAX = 64;
  localparam int RAM_BYTES     = 65536;
  localparam int APB_ADDR_W    = 5;
  localparam int APB_DATA_W    = 32;
  localparam int STEPS_PER_STG = 3;

  // program banking modes
  localparam logic [1:0] MODE_32K    = 2'd0;
  localparam logic [1:0] MODE_16_16  = 2'd1;
  localparam logic [1:0] MODE_16_8_8 = 2'd2;
  localparam logic [1:0] MODE_8X4    = 2'd3;

  typedef enum logic [1:0] {
    RGN_NONE = 2'd0,
    RGN_CTRL = 2'd1,
    RGN_RAM  = 2'd2,
    RGN_ROM  = 2'd3
  } region_t;

  typedef enum logic [2:0] {
    IDX_PRG_MODE  = 3'd0,
    IDX_RAM_BANK  = 3'd1,
    IDX_BANK_8000 = 3'd2,
    IDX_BANK_A000 = 3'd3,
    IDX_BANK_C000 = 3'd4,
    IDX_BANK_E000 = 3'd5,
    IDX_ROM_SIZE  = 3'd6,
    IDX_RAM_UNLK  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         prg_mode;
    logic [7:0]         ram_bank_select;
    logic [7:0]         bank_reg_8000;
    logic [7:0]         bank_reg_a000;
    logic [7:0]         bank_reg_c000;
    logic [7:0]         bank_reg_e000;
    logic [UNITS_W-1:0] rom_units;
    logic               ram_unlocked;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cpu_address;
    logic              opcode;
    logic [DATA_W-1:0] write_data;
  } in_beat_t;

  // page is consumed from the top, rem holds the partial remainder
  typedef struct packed {
    region_t               region;
    logic [PAGE_W-1:0]     page;
    logic [PAGE_W-1:0]     rem;
    logic [LOW_W-1:0]      low;
    logic [RAM_ADDR_W-1:0] ram_address;
    logic                  ram_write;
    logic [DATA_W-1:0]     ram_write_data;
  } pipe_t;

  // zero counts as one unit, anything above the maximum saturates
  function automatic logic [UNITS_W-1:0] clamp_units(input logic [UNITS_W-1:0] size);
    logic [UNITS_W-1:0] u;
    u = size;
    if (size == '0) u = UNITS_W'(1);
    else if (size > UNITS_W'(ROM_UNITS_MAX)) u = UNITS_W'(ROM_UNITS_MAX);
    return u;
  endfunction

  // one restoring remainder step: rem < units on entry and on exit
  function automatic logic [PAGE_W-1:0] mod_step(input logic [PAGE_W-1:0] rem,
                                                 input logic bit_in,
                                                 input logic [UNITS_W-1:0] units);
    logic [UNITS_W-1:0] t;
    t = {rem, bit_in};
    if (t >= units) t = t - units;
    return t[PAGE_W-1:0];
  endfunction

endpackage

@@ sv/pbam_if.sv @@
interface pbam_in_if import pbam_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] cpu_address;
  logic              opcode;
  logic [DATA_W-1:0] write_data;

  modport source(output valid, cpu_address, opcode, write_data, input ready);
  modport sink(input valid, cpu_address, opcode, write_data, output ready);
endinterface

interface pbam_out_if import pbam_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            region;
  logic [ROM_OFF_W-1:0]  rom_offset;
  logic [RAM_ADDR_W-1:0] ram_address;
  logic                  ram_write;
  logic [DATA_W-1:0]     ram_write_data;

  modport source(output valid, region, rom_offset, ram_address, ram_write, ram_write_data,
                 input ready);
  modport sink(input valid, region, rom_offset, ram_address, ram_write, ram_write_data,
               output ready);
endinterface

@@ sv/pbam_cfg.sv @@
module pbam_cfg import pbam_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [1:0]         prg_mode_r;
  logic [7:0]         ram_bank_r;
  logic [7:0]         bank_8000_r;
  logic [7:0]         bank_a000_r;
  logic [7:0]         bank_c000_r;
  logic [7:0]         bank_e000_r;
  logic [UNITS_W-1:0] rom_size_r;
  logic               ram_unlk_r;
  cfg_idx_t           idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = cfg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_mode_r  <= MODE_8X4;
      ram_bank_r  <= 8'd0;
      bank_8000_r <= 8'h80;
      bank_a000_r <= 8'h80;
      bank_c000_r <= 8'h80;
      bank_e000_r <= 8'hFF;
      rom_size_r  <= UNITS_W'(ROM_UNITS_MAX);
      ram_unlk_r  <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        IDX_PRG_MODE:  prg_mode_r  <= pwdata[1:0];
        IDX_RAM_BANK:  ram_bank_r  <= pwdata[7:0];
        IDX_BANK_8000: bank_8000_r <= pwdata[7:0];
        IDX_BANK_A000: bank_a000_r <= pwdata[7:0];
        IDX_BANK_C000: bank_c000_r <= pwdata[7:0];
        IDX_BANK_E000: bank_e000_r <= pwdata[7:0];
        IDX_ROM_SIZE:  rom_size_r  <= pwdata[UNITS_W-1:0];
        IDX_RAM_UNLK:  ram_unlk_r  <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      IDX_PRG_MODE:  prdata = APB_DATA_W'(prg_mode_r);
      IDX_RAM_BANK:  prdata = APB_DATA_W'(ram_bank_r);
      IDX_BANK_8000: prdata = APB_DATA_W'(bank_8000_r);
      IDX_BANK_A000: prdata = APB_DATA_W'(bank_a000_r);
      IDX_BANK_C000: prdata = APB_DATA_W'(bank_c000_r);
      IDX_BANK_E000: prdata = APB_DATA_W'(bank_e000_r);
      IDX_ROM_SIZE:  prdata = APB_DATA_W'(rom_size_r);
      IDX_RAM_UNLK:  prdata = APB_DATA_W'(ram_unlk_r);
    endcase
  end

  always_comb begin
    cfg.prg_mode        = prg_mode_r;
    cfg.ram_bank_select = ram_bank_r;
    cfg.bank_reg_8000   = bank_8000_r;
    cfg.bank_reg_a000   = bank_a000_r;
    cfg.bank_reg_c000   = bank_c000_r;
    cfg.bank_reg_e000   = bank_e000_r;
    cfg.rom_units       = clamp_units(rom_size_r);
    cfg.ram_unlocked    = ram_unlk_r;
  end

endmodule

@@ sv/pbam_decode.sv @@
module pbam_decode import pbam_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     valid_i,
  input  in_beat_t beat_i,
  output logic     ready_o,
  output logic     valid_o,
  output pipe_t    beat_o,
  input  logic     ready_i
);

  logic              valid_r;
  pipe_t             beat_r;
  pipe_t             beat_nxt;
  logic [ADDR_W-1:0] a;
  logic              wr;
  logic [7:0]        reg8;
  logic              force_rom;
  logic [RAM_BYTES > 65535 ? 16 : 16:0] ram_ext;

  assign a  = beat_i.cpu_address;
  assign wr = beat_i.opcode;

  // 8KB window register for modes where C000-FFFF or the whole space is split
  always_comb begin
    unique case (a[14:13])
      2'd0: reg8 = cfg.bank_reg_8000;
      2'd1: reg8 = cfg.bank_reg_a000;
      2'd2: reg8 = cfg.bank_reg_c000;
      2'd3: reg8 = cfg.bank_reg_e000;
    endcase
  end
  assign force_rom = (a[14:13] == 2'd3);

  always_comb begin
    beat_nxt.region         = RGN_NONE;
    beat_nxt.page           = '0;
    beat_nxt.rem            = '0;
    beat_nxt.low            = '0;
    beat_nxt.ram_address    = '0;
    beat_nxt.ram_write      = 1'b0;
    beat_nxt.ram_write_data = '0;

    priority if (a[15:12] == 4'h5) begin
      beat_nxt.region = RGN_CTRL;
    end else if (a[15:13] == 3'b011) begin
      beat_nxt.region      = RGN_RAM;
      beat_nxt.ram_address = {cfg.ram_bank_select[2:0], a[12:0]};
    end else if (a[15]) begin
      priority if (cfg.prg_mode == MODE_32K) begin
        beat_nxt.region = RGN_ROM;
        beat_nxt.page   = {cfg.bank_reg_e000[6:2], a[14]};
        beat_nxt.low    = a[13:0];
      end else if (cfg.prg_mode != MODE_8X4 && !a[14]) begin
        if (cfg.bank_reg_a000[7]) begin
          beat_nxt.region = RGN_ROM;
          beat_nxt.page   = cfg.bank_reg_a000[6:1];
          beat_nxt.low    = a[13:0];
        end else begin
          beat_nxt.region      = RGN_RAM;
          beat_nxt.ram_address = {cfg.bank_reg_a000[2:1], a[13:0]};
        end
      end else if (cfg.prg_mode == MODE_16_16) begin
        beat_nxt.region = RGN_ROM;
        beat_nxt.page   = cfg.bank_reg_e000[6:1];
        beat_nxt.low    = a[13:0];
      end else if (reg8[7] || force_rom) begin
        beat_nxt.region = RGN_ROM;
        beat_nxt.page   = reg8[6:1];
        beat_nxt.low    = {reg8[0], a[12:0]};
      end else begin
        beat_nxt.region      = RGN_RAM;
        beat_nxt.ram_address = {reg8[2:0], a[12:0]};
      end
    end else begin
      beat_nxt.region = RGN_NONE;
    end

    // writes into ROM are dropped
    if (wr && beat_nxt.region == RGN_ROM) beat_nxt.region = RGN_NONE;

    ram_ext = {1'b0, beat_nxt.ram_address};
    if (beat_nxt.region == RGN_RAM && ram_ext >= 17'(RAM_BYTES)) beat_nxt.region = RGN_NONE;

    if (beat_nxt.region != RGN_ROM) begin
      beat_nxt.page = '0;
      beat_nxt.low  = '0;
    end
    if (beat_nxt.region != RGN_RAM) beat_nxt.ram_address = '0;

    beat_nxt.ram_write      = (beat_nxt.region == RGN_RAM) && wr && cfg.ram_unlocked;
    beat_nxt.ram_write_data = beat_nxt.ram_write ? beat_i.write_data : '0;
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      beat_r <= beat_nxt;
    end
  end

  assign valid_o = valid_r;
  assign beat_o  = beat_r;

endmodule

@@ sv/pbam_mod_stage.sv @@
module pbam_mod_stage import pbam_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [UNITS_W-1:0] units,
  input  logic               valid_i,
  input  pipe_t              beat_i,
  output logic               ready_o,
  output logic               valid_o,
  output pipe_t              beat_o,
  input  logic               ready_i
);

  logic  valid_r;
  pipe_t beat_r;
  pipe_t beat_nxt;

  // take three page bits from the top into the remainder
  always_comb begin
    beat_nxt = beat_i;
    for (int i = 0; i < STEPS_PER_STG; i++) begin
      beat_nxt.rem  = mod_step(beat_nxt.rem, beat_nxt.page[PAGE_W-1], units);
      beat_nxt.page = {beat_nxt.page[PAGE_W-2:0], 1'b0};
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      beat_r <= beat_nxt;
    end
  end

  assign valid_o = valid_r;
  assign beat_o  = beat_r;

endmodule

@@ sv/prg_bank_address_map_core.sv @@
// Program bank address map: turns one CPU bus access into a region code and a
// ROM byte offset or a RAM byte address under the selected banking mode.
// Input channel in_bus: one access per beat (cpu_address, opcode, write_data).
// Result channel out_bus: exactly one result beat per access, in order.
// Configuration: APB-style registers at byte address 4*index, written with a
// setup and an access phase; pready is tied high. Change them only while no
// access is in flight.
// Pipeline: a decode register, then two stages of ROM page remainder with three
// remainder steps each; the last stage is the output register.
// Throughput: one access per cycle while out_bus.ready is high; every stage
// holds its own valid bit.
// Stall: a stage holds while its successor is full and stalled, so bubbles in
// the pipeline still fill while out_bus.ready is low; nothing is lost or
// repeated.
// Reset: synchronous, active low; clears all valid bits and returns the
// registers to mode 3, all ROM banks and RAM locked.
module prg_bank_address_map_core import pbam_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pbam_in_if.sink               in_bus,
  pbam_out_if.source            out_bus,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg;
  in_beat_t in_beat;
  logic     s1_valid, s1_ready;
  pipe_t    s1_beat;
  logic     s2_valid, s2_ready;
  pipe_t    s2_beat;
  pipe_t    s3_beat;

  pbam_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_beat.cpu_address = in_bus.cpu_address;
  assign in_beat.opcode      = in_bus.opcode;
  assign in_beat.write_data  = in_bus.write_data;

  pbam_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .valid_i (in_bus.valid),
    .beat_i  (in_beat),
    .ready_o (in_bus.ready),
    .valid_o (s1_valid),
    .beat_o  (s1_beat),
    .ready_i (s1_ready)
  );

  pbam_mod_stage u_mod_hi (
    .clk     (clk),
    .rst_n   (rst_n),
    .units   (cfg.rom_units),
    .valid_i (s1_valid),
    .beat_i  (s1_beat),
    .ready_o (s1_ready),
    .valid_o (s2_valid),
    .beat_o  (s2_beat),
    .ready_i (s2_ready)
  );

  pbam_mod_stage u_mod_lo (
    .clk     (clk),
    .rst_n   (rst_n),
    .units   (cfg.rom_units),
    .valid_i (s2_valid),
    .beat_i  (s2_beat),
    .ready_o (s2_ready),
    .valid_o (out_bus.valid),
    .beat_o  (s3_beat),
    .ready_i (out_bus.ready)
  );

  // page and low are zero outside ROM, so the offset is zero there too
  assign out_bus.region         = s3_beat.region;
  assign out_bus.rom_offset     = {s3_beat.rem, s3_beat.low};
  assign out_bus.ram_address    = s3_beat.ram_address;
  assign out_bus.ram_write      = s3_beat.ram_write;
  assign out_bus.ram_write_data = s3_beat.ram_write_data;

endmodule

@@ sv/pbam_checker.sv @@
module pbam_checker import pbam_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            out_region,
  input logic [ROM_OFF_W-1:0]  out_rom_offset,
  input logic [RAM_ADDR_W-1:0] out_ram_address,
  input logic                  out_ram_write,
  input logic [DATA_W-1:0]     out_ram_write_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_region)
      && $stable(out_rom_offset) && $stable(out_ram_address))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_strobe_ram: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ram_write |-> out_region == RGN_RAM)
    else $error("RAM write strobe outside RAM region");

  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_region != RGN_ROM |-> out_rom_offset == '0)
    else $error("ROM offset set outside ROM region");

  a_data_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ram_write |-> out_ram_write_data == '0
      && (out_region == RGN_RAM || out_ram_address == '0))
    else $error("write data or RAM address leaked");

endmodule

bind prg_bank_address_map_core pbam_checker u_pbam_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_bus.valid),
  .out_ready          (out_bus.ready),
  .out_region         (out_bus.region),
  .out_rom_offset     (out_bus.rom_offset),
  .out_ram_address    (out_bus.ram_address),
  .out_ram_write      (out_bus.ram_write),
  .out_ram_write_data (out_bus.ram_write_data)
);
